// ===== rtl/core/i2cms_pkg.sv =====
// Shared types and constants for the I2C bit-level master sequencer.
package i2cms_pkg;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_WRITE = 3'd1,
    OP_CHECK = 3'd2,
    OP_READ  = 3'd3,
    OP_SACK  = 3'd4,
    OP_STOP  = 3'd5
  } op_t;

  localparam int unsigned PHASE_W = 5;
  localparam int unsigned BYTE_W  = 8;

  // Index of the last phase of each command.
  localparam logic [PHASE_W-1:0] LAST_START = 5'd2;
  localparam logic [PHASE_W-1:0] LAST_WRITE = 5'd24;
  localparam logic [PHASE_W-1:0] LAST_CHECK = 5'd2;
  localparam logic [PHASE_W-1:0] LAST_READ  = 5'd16;
  localparam logic [PHASE_W-1:0] LAST_SACK  = 5'd3;
  localparam logic [PHASE_W-1:0] LAST_STOP  = 5'd2;

  // Position inside one written bit: set data, raise SCL, lower SCL.
  localparam logic [1:0] BIT_DATA = 2'd0;
  localparam logic [1:0] BIT_HIGH = 2'd1;
  localparam logic [1:0] BIT_LOW  = 2'd2;

endpackage

// ===== rtl/core/i2c_bit_level_master_sequencer.sv =====
// Top level of the I2C bit-level master sequencer: one bus phase per tick item.
// An accepted tick item shows its result in the next cycle, from the output register.
// Throughput: one tick item per cycle; the phase update and the output register
// form a single pass, and input stall follows only a held, stalled result.
// Reset: synchronous, active high; SCL and SDA state high, SDA driven, no command
// in progress, rx shift and ack bit cleared; only out_valid of the outputs resets.
module i2c_bit_level_master_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd_valid,
  input  logic [2:0]                      op,
  input  logic [i2cms_pkg::BYTE_W-1:0]    tx_byte,
  input  logic                            ack_level,
  input  logic                            sda_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            scl_level,
  output logic                            sda_level,
  output logic                            sda_drive,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [i2cms_pkg::BYTE_W-1:0]    rx_byte,
  output logic                            ack_received
);
  import i2cms_pkg::*;

  logic               busy, busy_next;
  op_t                active_op, active_op_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [1:0]         bit_pos, bit_pos_next;
  logic [BYTE_W-1:0]  tx_shift, tx_shift_next;
  logic [BYTE_W-1:0]  rx_shift, rx_shift_next;
  logic               ack_bit, ack_bit_next;
  logic               scl, scl_next;
  logic               sda, sda_next;
  logic               drive, drive_next;
  logic [PHASE_W-1:0] last_phase;
  logic [PHASE_W-1:0] p;
  logic               res_busy, res_done;
  logic               accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    busy_next      = busy;
    active_op_next = active_op;
    phase_next     = phase;
    bit_pos_next   = bit_pos;
    tx_shift_next  = tx_shift;
    rx_shift_next  = rx_shift;
    ack_bit_next   = ack_bit;
    scl_next       = scl;
    sda_next       = sda;
    drive_next     = drive;
    res_busy       = 1'b0;
    res_done       = 1'b0;
    last_phase     = LAST_STOP;

    // Take a new command only while idle; undefined op codes drop.
    if (!busy && cmd_valid && (op <= 3'(OP_STOP))) begin
      busy_next      = 1'b1;
      active_op_next = op_t'(op);
      phase_next     = '0;
      bit_pos_next   = BIT_DATA;
      if (op == 3'(OP_WRITE)) begin
        tx_shift_next = tx_byte;
      end else if (op == 3'(OP_SACK)) begin
        tx_shift_next = {{(BYTE_W-1){1'b0}}, ack_level};
      end else if (op == 3'(OP_READ)) begin
        rx_shift_next = '0;
      end
    end

    p = phase_next;

    if (busy_next) begin
      res_busy = 1'b1;
      unique case (active_op_next)
        OP_START: begin
          last_phase = LAST_START;
          if (p == '0) begin
            scl_next = 1'b1; sda_next = 1'b1; drive_next = 1'b1;
          end else if (p == 5'd1) begin
            sda_next = 1'b0;
          end else begin
            scl_next = 1'b0;
          end
        end
        OP_WRITE: begin
          last_phase = LAST_WRITE;
          if (p == '0) begin
            scl_next = 1'b0; drive_next = 1'b1;
          end else begin
            unique case (bit_pos_next)
              BIT_DATA: begin
                sda_next      = tx_shift_next[BYTE_W-1];
                tx_shift_next = {tx_shift_next[BYTE_W-2:0], 1'b0};
              end
              BIT_HIGH: scl_next = 1'b1;
              default:  scl_next = 1'b0;
            endcase
            bit_pos_next = (bit_pos_next == BIT_LOW) ? BIT_DATA : bit_pos_next + 2'd1;
          end
        end
        OP_CHECK: begin
          last_phase = LAST_CHECK;
          if (p == '0) begin
            scl_next = 1'b0; drive_next = 1'b0;
          end else if (p == 5'd1) begin
            scl_next = 1'b1;
          end else begin
            scl_next     = 1'b0;
            ack_bit_next = sda_in;
          end
        end
        OP_READ: begin
          last_phase = LAST_READ;
          if (p == '0) begin
            scl_next = 1'b0; drive_next = 1'b0;
          end else if (p[0]) begin
            scl_next = 1'b1;
          end else begin
            scl_next      = 1'b0;
            rx_shift_next = {rx_shift_next[BYTE_W-2:0], sda_in};
          end
        end
        OP_SACK: begin
          last_phase = LAST_SACK;
          if (p == '0) begin
            scl_next = 1'b0; drive_next = 1'b1;
          end else if (p == 5'd1) begin
            sda_next = tx_shift_next[0];
          end else if (p == 5'd2) begin
            scl_next = 1'b1;
          end else begin
            scl_next = 1'b0;
          end
        end
        default: begin
          last_phase = LAST_STOP;
          if (p == '0) begin
            scl_next = 1'b0; sda_next = 1'b0; drive_next = 1'b1;
          end else if (p == 5'd1) begin
            scl_next = 1'b1;
          end else begin
            sda_next = 1'b1;
          end
        end
      endcase

      // Drop busy after the last phase, else advance.
      if (p >= last_phase) begin
        res_done   = 1'b1;
        busy_next  = 1'b0;
        phase_next = '0;
      end else begin
        phase_next = p + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      active_op <= OP_START;
      phase     <= '0;
      bit_pos   <= BIT_DATA;
      tx_shift  <= '0;
      rx_shift  <= '0;
      ack_bit   <= 1'b0;
      scl       <= 1'b1;
      sda       <= 1'b1;
      drive     <= 1'b1;
    end else if (accept) begin
      busy      <= busy_next;
      active_op <= active_op_next;
      phase     <= phase_next;
      bit_pos   <= bit_pos_next;
      tx_shift  <= tx_shift_next;
      rx_shift  <= rx_shift_next;
      ack_bit   <= ack_bit_next;
      scl       <= scl_next;
      sda       <= sda_next;
      drive     <= drive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scl_level    <= scl_next;
      sda_level    <= sda_next;
      sda_drive    <= drive_next;
      busy_res     <= res_busy;
      done_res     <= res_done;
      rx_byte      <= rx_shift_next;
      ack_received <= ack_bit_next;
    end
  end

  a_idle_phase_zero: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (phase == '0))
    else $error("phase counter not cleared while idle");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (phase <= LAST_WRITE))
    else $error("phase counter past the longest command");

  a_done_implies_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> busy_res)
    else $error("done result without busy");

  a_accept_fills_output: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item left no result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

endmodule
